// ===== rtl/core/scr_pkg.sv =====
`default_nettype none

package scr_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned SEL_W    = 14;
    localparam int unsigned ID_WORDS = 16;
    localparam int unsigned RAM_DEPTH = 29;
    localparam int unsigned RAM_AW   = $clog2(RAM_DEPTH);
    localparam int unsigned IDX_W    = 6;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access rights of a map entry
    localparam logic [3:0] ACC_R  = 4'b0001;
    localparam logic [3:0] ACC_RU = 4'b0010;
    localparam logic [3:0] ACC_W  = 4'b0100;
    localparam logic [3:0] ACC_WU = 4'b1000;
    localparam logic [3:0] ACC_RW = ACC_R | ACC_W;

    // Decoded access, handed from the decoder to the datapath
    typedef struct packed {
        logic              hit;
        logic              rd_id;
        logic              rd_ram;
        logic              wr_ram;
        logic [3:0]        id_idx;
        logic [RAM_AW-1:0] ram_addr;
    } t_dec;

    function automatic logic [DATA_W-1:0] id_word(input logic [3:0] idx);
        logic [DATA_W-1:0] w;
        case (idx)
            4'd0:    w = 32'h410F_B024;
            4'd1:    w = 32'h0F0D_2112;
            4'd2:    w = 32'h0000_0800;
            4'd3:    w = 32'h0000_0B00;
            4'd4:    w = 32'h0000_0111;
            4'd5:    w = 32'h0000_0001;
            4'd6:    w = 32'h0000_0002;
            4'd7:    w = 32'h0110_0103;
            4'd8:    w = 32'h1002_0302;
            4'd9:    w = 32'h0122_2000;
            4'd10:   w = 32'h0000_0000;
            4'd11:   w = 32'h0010_0011;
            4'd12:   w = 32'h1200_2111;
            4'd13:   w = 32'h1122_1011;
            4'd14:   w = 32'h0110_2131;
            4'd15:   w = 32'h0000_0141;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scr_ram.sv =====
`default_nettype none

module scr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 29
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/scr_decode.sv =====
`default_nettype none

module scr_decode (
    input  wire logic                    i_opcode,
    input  wire logic [3:0]              i_primary_reg,
    input  wire logic [2:0]              i_first_op,
    input  wire logic [3:0]              i_secondary_reg,
    input  wire logic [2:0]              i_second_op,
    input  wire logic                    i_privileged,
    output scr_pkg::t_dec                o_dec
);
    import scr_pkg::*;

    typedef struct packed {
        logic             mapped;
        logic             stored;
        logic [IDX_W-1:0] idx;
        logic [3:0]       acc;
    } t_map;

    function automatic t_map word(input logic [IDX_W-1:0] idx, input logic [3:0] acc);
        t_map m;
        m.mapped = 1'b1;
        m.stored = 1'b1;
        m.idx    = idx;
        m.acc    = acc;
        return m;
    endfunction

    function automatic t_map op(input logic [3:0] acc);
        t_map m;
        m.mapped = 1'b1;
        m.stored = 1'b0;
        m.idx    = '0;
        m.acc    = acc;
        return m;
    endfunction

    logic [SEL_W-1:0] sel;
    t_map             m;
    logic             rd_ok;
    logic             wr_ok;
    logic [IDX_W-1:0] ram_idx;

    assign sel = {i_primary_reg, i_first_op, i_secondary_reg, i_second_op};

    always_comb begin
        case (sel)
            {4'd0, 3'd0, 4'd0, 3'd0}:   m = word(6'd0,  ACC_R);
            {4'd0, 3'd0, 4'd0, 3'd1}:   m = word(6'd1,  ACC_R);
            {4'd0, 3'd0, 4'd0, 3'd3}:   m = word(6'd2,  ACC_R);
            {4'd0, 3'd0, 4'd0, 3'd5}:   m = word(6'd3,  ACC_R);
            {4'd0, 3'd0, 4'd1, 3'd0}:   m = word(6'd4,  ACC_R);
            {4'd0, 3'd0, 4'd1, 3'd1}:   m = word(6'd5,  ACC_R);
            {4'd0, 3'd0, 4'd1, 3'd2}:   m = word(6'd6,  ACC_R);
            {4'd0, 3'd0, 4'd1, 3'd4}:   m = word(6'd7,  ACC_R);
            {4'd0, 3'd0, 4'd1, 3'd5}:   m = word(6'd8,  ACC_R);
            {4'd0, 3'd0, 4'd1, 3'd6}:   m = word(6'd9,  ACC_R);
            {4'd0, 3'd0, 4'd1, 3'd7}:   m = word(6'd10, ACC_R);
            {4'd0, 3'd0, 4'd2, 3'd0}:   m = word(6'd11, ACC_R);
            {4'd0, 3'd0, 4'd2, 3'd1}:   m = word(6'd12, ACC_R);
            {4'd0, 3'd0, 4'd2, 3'd2}:   m = word(6'd13, ACC_R);
            {4'd0, 3'd0, 4'd2, 3'd3}:   m = word(6'd14, ACC_R);
            {4'd0, 3'd0, 4'd2, 3'd4}:   m = word(6'd15, ACC_R);
            {4'd1, 3'd0, 4'd0, 3'd0}:   m = word(6'd16, ACC_RW);
            {4'd1, 3'd0, 4'd0, 3'd1}:   m = word(6'd17, ACC_RW);
            {4'd1, 3'd0, 4'd0, 3'd2}:   m = word(6'd18, ACC_RW);
            {4'd2, 3'd0, 4'd0, 3'd0}:   m = word(6'd19, ACC_RW);
            {4'd2, 3'd0, 4'd0, 3'd1}:   m = word(6'd20, ACC_RW);
            {4'd2, 3'd0, 4'd0, 3'd2}:   m = word(6'd21, ACC_RW);
            {4'd3, 3'd0, 4'd0, 3'd0}:   m = word(6'd22, ACC_RW);
            {4'd5, 3'd0, 4'd0, 3'd0}:   m = word(6'd23, ACC_RW);
            {4'd5, 3'd0, 4'd0, 3'd1}:   m = word(6'd24, ACC_RW);
            {4'd6, 3'd0, 4'd0, 3'd0}:   m = word(6'd25, ACC_RW);
            {4'd6, 3'd0, 4'd0, 3'd1}:   m = word(6'd26, ACC_RW);
            {4'd7, 3'd0, 4'd4, 3'd0}:   m = word(6'd27, ACC_RW);
            {4'd9, 3'd0, 4'd0, 3'd0}:   m = word(6'd28, ACC_RW);
            {4'd10, 3'd0, 4'd0, 3'd0}:  m = word(6'd29, ACC_RW);
            {4'd10, 3'd0, 4'd2, 3'd0}:  m = word(6'd30, ACC_RW);
            {4'd10, 3'd0, 4'd2, 3'd1}:  m = word(6'd31, ACC_RW);
            {4'd13, 3'd0, 4'd0, 3'd0}:  m = word(6'd32, ACC_RW);
            {4'd13, 3'd0, 4'd0, 3'd1}:  m = word(6'd33, ACC_RW);
            {4'd13, 3'd0, 4'd0, 3'd2}:  m = word(6'd34, ACC_RU | ACC_WU);
            {4'd13, 3'd0, 4'd0, 3'd3}:  m = word(6'd35, ACC_RU | ACC_W);
            {4'd13, 3'd0, 4'd0, 3'd4}:  m = word(6'd36, ACC_RW);
            {4'd15, 3'd0, 4'd12, 3'd0}: m = word(6'd37, ACC_RW);
            {4'd15, 3'd0, 4'd12, 3'd1}: m = word(6'd38, ACC_RW);
            {4'd15, 3'd0, 4'd12, 3'd2}: m = word(6'd39, ACC_RW);
            {4'd15, 3'd0, 4'd12, 3'd3}: m = word(6'd40, ACC_RW);
            {4'd15, 3'd5, 4'd5, 3'd2}:  m = word(6'd41, ACC_RW);
            {4'd15, 3'd5, 4'd6, 3'd2}:  m = word(6'd42, ACC_RW);
            {4'd15, 3'd5, 4'd7, 3'd2}:  m = word(6'd43, ACC_RW);
            {4'd15, 3'd7, 4'd1, 3'd0}:  m = word(6'd44, ACC_RW);
            // cache, TLB, barrier and wait operations: acknowledged, never stored
            {4'd7, 3'd0, 4'd0, 3'd4},
            {4'd7, 3'd0, 4'd5, 3'd0},
            {4'd7, 3'd0, 4'd5, 3'd1},
            {4'd7, 3'd0, 4'd5, 3'd2},
            {4'd7, 3'd0, 4'd5, 3'd6},
            {4'd7, 3'd0, 4'd5, 3'd7},
            {4'd7, 3'd0, 4'd6, 3'd0},
            {4'd7, 3'd0, 4'd6, 3'd1},
            {4'd7, 3'd0, 4'd6, 3'd2},
            {4'd7, 3'd0, 4'd7, 3'd0},
            {4'd7, 3'd0, 4'd10, 3'd0},
            {4'd7, 3'd0, 4'd10, 3'd1},
            {4'd7, 3'd0, 4'd10, 3'd2},
            {4'd7, 3'd0, 4'd14, 3'd0},
            {4'd7, 3'd0, 4'd14, 3'd1},
            {4'd7, 3'd0, 4'd14, 3'd2},
            {4'd8, 3'd0, 4'd5, 3'd0},
            {4'd8, 3'd0, 4'd5, 3'd1},
            {4'd8, 3'd0, 4'd5, 3'd2},
            {4'd8, 3'd0, 4'd5, 3'd3},
            {4'd8, 3'd0, 4'd6, 3'd0},
            {4'd8, 3'd0, 4'd6, 3'd1},
            {4'd8, 3'd0, 4'd6, 3'd2},
            {4'd8, 3'd0, 4'd6, 3'd3},
            {4'd8, 3'd0, 4'd7, 3'd0},
            {4'd8, 3'd0, 4'd7, 3'd1},
            {4'd8, 3'd0, 4'd7, 3'd2},
            {4'd8, 3'd0, 4'd7, 3'd3},
            {4'd15, 3'd5, 4'd4, 3'd2},
            {4'd15, 3'd5, 4'd4, 3'd4}:  m = op(ACC_W);
            {4'd7, 3'd0, 4'd5, 3'd4},
            {4'd7, 3'd0, 4'd10, 3'd4},
            {4'd7, 3'd0, 4'd10, 3'd5}:  m = op(ACC_WU);
            default:                    m = '0;
        endcase
    end

    assign rd_ok = m.mapped && m.stored
                   && ((|(m.acc & ACC_RU)) || ((|(m.acc & ACC_R)) && i_privileged));
    assign wr_ok = m.mapped
                   && ((|(m.acc & ACC_WU)) || ((|(m.acc & ACC_W)) && i_privileged));

    // Words above the identification block live in the RAM
    assign ram_idx = m.idx - IDX_W'(ID_WORDS);

    always_comb begin
        o_dec          = '0;
        o_dec.id_idx   = m.idx[3:0];
        o_dec.ram_addr = ram_idx[RAM_AW-1:0];
        if (i_opcode == OP_READ) begin
            o_dec.hit    = rd_ok;
            o_dec.rd_id  = rd_ok && (m.idx < IDX_W'(ID_WORDS));
            o_dec.rd_ram = rd_ok && (m.idx >= IDX_W'(ID_WORDS));
        end else begin
            o_dec.hit    = wr_ok;
            o_dec.wr_ram = wr_ok && m.stored && (m.idx >= IDX_W'(ID_WORDS));
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/system_control_register_file_top.sv =====
// Channel | Direction | Handshake        | Beat
// in      | in        | i_valid/o_stall  | opcode, selectors, write value, privilege
// out     | out       | o_valid/i_stall  | read_data, hit
//
// Each access is decoded and its RAM read issued as the beat enters the pending
// stage; the result register follows. One beat per cycle is taken while the result
// stage drains; each beat makes at most one RAM access, read or write.
// Reset clears the handshake state and the RAM valid bits; words never
// written read as zero, identification words come from a constant table.
// A stalled result holds; one more access waits behind it in a pending stage.
`default_nettype none

module system_control_register_file_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_opcode,
    input  wire logic [3:0]                  i_primary_reg,
    input  wire logic [2:0]                  i_first_op,
    input  wire logic [3:0]                  i_secondary_reg,
    input  wire logic [2:0]                  i_second_op,
    input  wire logic [31:0]                 i_write_value,
    input  wire logic                        i_privileged,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [31:0]                      o_read_data,
    output logic                             o_hit
);
    import scr_pkg::*;

    t_dec              dec;
    logic              accept;
    logic              p_move;
    logic [DATA_W-1:0] ram_rdata;

    logic                 r_p_valid;
    logic                 r_p_hit;
    logic                 r_p_use_ram;
    logic [DATA_W-1:0]    r_p_data;
    logic                 r_o_valid;
    logic                 r_o_hit;
    logic [DATA_W-1:0]    r_o_data;
    logic [RAM_DEPTH-1:0] r_vld;

    scr_decode u_decode (
        .i_opcode        (i_opcode),
        .i_primary_reg   (i_primary_reg),
        .i_first_op      (i_first_op),
        .i_secondary_reg (i_secondary_reg),
        .i_second_op     (i_second_op),
        .i_privileged    (i_privileged),
        .o_dec           (dec)
    );

    assign p_move  = r_p_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_p_valid && !p_move;
    assign accept  = i_valid && !o_stall;

    scr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && dec.wr_ram),
        .i_waddr (dec.ram_addr),
        .i_wdata (i_write_value),
        .i_re    (accept && dec.rd_ram),
        .i_raddr (dec.ram_addr),
        .o_rdata (ram_rdata)
    );

    // Mark RAM words once written; unwritten words read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (accept && dec.wr_ram) begin
            r_vld[dec.ram_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_hit     <= dec.hit;
            r_p_use_ram <= dec.rd_ram && r_vld[dec.ram_addr];
            r_p_data    <= dec.rd_id ? id_word(dec.id_idx) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (p_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move) begin
            r_o_hit  <= r_p_hit;
            r_o_data <= r_p_use_ram ? ram_rdata : r_p_data;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_read_data = r_o_data;
    assign o_hit       = r_o_hit;

endmodule

`default_nettype wire

// ===== rtl/core/scr_checker.sv =====
`default_nettype none

module scr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_read_data,
    input wire logic        o_hit
);

    // Nonzero data only comes from a read hit
    a_data_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_read_data != 32'h0) |-> o_hit)
        else $error("read data without hit");

    // A fresh result follows an input beat taken through the pending stage into the result register
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without matching input beat");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data) && $stable(o_hit))
        else $error("stalled result changed");

endmodule

bind system_control_register_file_top scr_checker u_scr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_read_data (o_read_data),
    .o_hit       (o_hit)
);

`default_nettype wire

// ===== bench/system_control_register_file_top_test.sv =====
`default_nettype none

module system_control_register_file_top_test;
    import scr_pkg::*;

    localparam int STORED_WORDS = 45;
    localparam int MAP_ENTRIES  = 78;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  primary_reg;
        logic [2:0]  first_op;
        logic [3:0]  secondary_reg;
        logic [2:0]  second_op;
        logic [31:0] write_value;
        logic        privileged;
    } t_access;

    typedef struct packed {
        logic [31:0] read_data;
        logic        hit;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    t_access     cur_access = '0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic        o_hit;

    // Selector tuple {primary, first_op, secondary, second_op} and rights;
    // the first STORED_WORDS entries are the stored words in store order.
    logic [13:0] map_sel [0:MAP_ENTRIES-1];
    logic [3:0]  map_acc [0:MAP_ENTRIES-1];
    int          map_count = 0;
    logic [31:0] sysreg_store [0:STORED_WORDS-1];

    t_access     access_queue[$];
    t_result     pending_results[$];
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    t_access     beat;
    t_result     want;

    system_control_register_file_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (cur_access.opcode),
        .i_primary_reg  (cur_access.primary_reg),
        .i_first_op     (cur_access.first_op),
        .i_secondary_reg(cur_access.secondary_reg),
        .i_second_op    (cur_access.second_op),
        .i_write_value  (cur_access.write_value),
        .i_privileged   (cur_access.privileged),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_hit          (o_hit)
    );

    always #5 i_clk = ~i_clk;

    task automatic map_add(input int n, input int a, input int m, input int b,
                           input logic [3:0] fl);
        map_sel[map_count] = {4'(n), 3'(a), 4'(m), 3'(b)};
        map_acc[map_count] = fl;
        map_count++;
    endtask

    // Decode one access against the map and update the store
    function automatic t_result sysreg_access(input t_access acc);
        t_result     r;
        logic [13:0] sel;
        logic [3:0]  fl;
        int          idx;
        r = '0;
        fl = '0;
        idx = -1;
        sel = {acc.primary_reg, acc.first_op, acc.secondary_reg, acc.second_op};
        for (int i = 0; i < MAP_ENTRIES; i++)
            if (idx < 0 && map_sel[i] == sel)
                idx = i;
        if (idx >= 0) begin
            fl = map_acc[idx];
            if (acc.opcode == OP_WRITE) begin
                if ((fl & ACC_WU) != 0 || ((fl & ACC_W) != 0 && acc.privileged)) begin
                    r.hit = 1'b1;
                    // write-only operation words keep nothing
                    if (idx < STORED_WORDS)
                        sysreg_store[idx] = acc.write_value;
                end
            end else if (((fl & ACC_RU) != 0 || ((fl & ACC_R) != 0 && acc.privileged))
                         && idx < STORED_WORDS) begin
                r.hit = 1'b1;
                r.read_data = sysreg_store[idx];
            end
        end
        return r;
    endfunction

    function automatic t_access access_of(input logic op, input int n,
                                          input int a, input int m,
                                          input int b, input logic [31:0] val,
                                          input logic priv);
        t_access acc;
        acc.opcode = op;
        acc.primary_reg = 4'(n);
        acc.first_op = 3'(a);
        acc.secondary_reg = 4'(m);
        acc.second_op = 3'(b);
        acc.write_value = val;
        acc.privileged = priv;
        return acc;
    endfunction

    // Mostly mapped tuples with random content, the rest anywhere in the space
    function automatic t_access random_access();
        t_access acc;
        int      k;
        acc.opcode = 1'($urandom_range(1));
        acc.write_value = $urandom;
        case ($urandom_range(7))
            0: acc.write_value = '0;
            1: acc.write_value = '1;
            default: ;
        endcase
        acc.privileged = ($urandom_range(3) != 0);
        if ($urandom_range(9) < 7) begin
            k = $urandom_range(MAP_ENTRIES - 1);
            {acc.primary_reg, acc.first_op, acc.secondary_reg, acc.second_op} = map_sel[k];
        end else begin
            {acc.primary_reg, acc.first_op, acc.secondary_reg, acc.second_op} =
                14'($urandom);
        end
        return acc;
    endfunction

    task automatic run_phase(input int sender_pct, input int recv_pct, input int count);
        sender_idle_pct = sender_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
            access_queue.push_back(random_access());
        while (access_queue.size() != 0 || i_valid || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: advance to the next beat once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                pending_results.push_back(sysreg_access(cur_access));
            if (!i_valid || !o_stall) begin
                if (access_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    beat = access_queue.pop_front();
                    cur_access <= beat;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: match each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected: read_data %h hit %b",
                         $time, o_read_data, o_hit);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.read_data) begin
                    $display("%0t: read_data mismatch: expected %h, got %h",
                             $time, want.read_data, o_read_data);
                    errors++;
                end
                if (o_hit !== want.hit) begin
                    $display("%0t: hit mismatch: expected %b, got %b",
                             $time, want.hit, o_hit);
                    errors++;
                end
            end
        end
    end

    initial begin
        map_add(0,0,0,0,ACC_R);   map_add(0,0,0,1,ACC_R);   map_add(0,0,0,3,ACC_R);
        map_add(0,0,0,5,ACC_R);
        map_add(0,0,1,0,ACC_R);   map_add(0,0,1,1,ACC_R);   map_add(0,0,1,2,ACC_R);
        map_add(0,0,1,4,ACC_R);   map_add(0,0,1,5,ACC_R);   map_add(0,0,1,6,ACC_R);
        map_add(0,0,1,7,ACC_R);
        map_add(0,0,2,0,ACC_R);   map_add(0,0,2,1,ACC_R);   map_add(0,0,2,2,ACC_R);
        map_add(0,0,2,3,ACC_R);   map_add(0,0,2,4,ACC_R);
        map_add(1,0,0,0,ACC_RW);  map_add(1,0,0,1,ACC_RW);  map_add(1,0,0,2,ACC_RW);
        map_add(2,0,0,0,ACC_RW);  map_add(2,0,0,1,ACC_RW);  map_add(2,0,0,2,ACC_RW);
        map_add(3,0,0,0,ACC_RW);
        map_add(5,0,0,0,ACC_RW);  map_add(5,0,0,1,ACC_RW);
        map_add(6,0,0,0,ACC_RW);  map_add(6,0,0,1,ACC_RW);
        map_add(7,0,4,0,ACC_RW);
        map_add(9,0,0,0,ACC_RW);
        map_add(10,0,0,0,ACC_RW); map_add(10,0,2,0,ACC_RW); map_add(10,0,2,1,ACC_RW);
        map_add(13,0,0,0,ACC_RW); map_add(13,0,0,1,ACC_RW);
        map_add(13,0,0,2,ACC_RU | ACC_WU); map_add(13,0,0,3,ACC_RU | ACC_W);
        map_add(13,0,0,4,ACC_RW);
        map_add(15,0,12,0,ACC_RW); map_add(15,0,12,1,ACC_RW);
        map_add(15,0,12,2,ACC_RW); map_add(15,0,12,3,ACC_RW);
        map_add(15,5,5,2,ACC_RW); map_add(15,5,6,2,ACC_RW); map_add(15,5,7,2,ACC_RW);
        map_add(15,7,1,0,ACC_RW);
        map_add(7,0,0,4,ACC_W);
        map_add(7,0,5,0,ACC_W);   map_add(7,0,5,1,ACC_W);   map_add(7,0,5,2,ACC_W);
        map_add(7,0,5,6,ACC_W);   map_add(7,0,5,7,ACC_W);
        map_add(7,0,6,0,ACC_W);   map_add(7,0,6,1,ACC_W);   map_add(7,0,6,2,ACC_W);
        map_add(7,0,7,0,ACC_W);
        map_add(7,0,10,0,ACC_W);  map_add(7,0,10,1,ACC_W);  map_add(7,0,10,2,ACC_W);
        map_add(7,0,14,0,ACC_W);  map_add(7,0,14,1,ACC_W);  map_add(7,0,14,2,ACC_W);
        map_add(8,0,5,0,ACC_W);   map_add(8,0,5,1,ACC_W);   map_add(8,0,5,2,ACC_W);
        map_add(8,0,5,3,ACC_W);
        map_add(8,0,6,0,ACC_W);   map_add(8,0,6,1,ACC_W);   map_add(8,0,6,2,ACC_W);
        map_add(8,0,6,3,ACC_W);
        map_add(8,0,7,0,ACC_W);   map_add(8,0,7,1,ACC_W);   map_add(8,0,7,2,ACC_W);
        map_add(8,0,7,3,ACC_W);
        map_add(15,5,4,2,ACC_W);  map_add(15,5,4,4,ACC_W);
        map_add(7,0,5,4,ACC_WU);  map_add(7,0,10,4,ACC_WU); map_add(7,0,10,5,ACC_WU);

        for (int i = 0; i < STORED_WORDS; i++)
            sysreg_store[i] = '0;
        sysreg_store[0]  = 32'h410F_B024; sysreg_store[1]  = 32'h0F0D_2112;
        sysreg_store[2]  = 32'h0000_0800; sysreg_store[3]  = 32'h0000_0B00;
        sysreg_store[4]  = 32'h0000_0111; sysreg_store[5]  = 32'h0000_0001;
        sysreg_store[6]  = 32'h0000_0002; sysreg_store[7]  = 32'h0110_0103;
        sysreg_store[8]  = 32'h1002_0302; sysreg_store[9]  = 32'h0122_2000;
        sysreg_store[10] = 32'h0000_0000; sysreg_store[11] = 32'h0010_0011;
        sysreg_store[12] = 32'h1200_2111; sysreg_store[13] = 32'h1122_1011;
        sysreg_store[14] = 32'h0110_2131; sysreg_store[15] = 32'h0000_0141;

        // identification words: read, user-mode read, ignored write
        access_queue.push_back(access_of(OP_READ,  0, 0, 0, 0, '0, 1'b1));
        access_queue.push_back(access_of(OP_READ,  0, 0, 2, 4, '1, 1'b1));
        access_queue.push_back(access_of(OP_READ,  0, 0, 0, 0, '0, 1'b0));
        access_queue.push_back(access_of(OP_WRITE, 0, 0, 0, 0, '1, 1'b1));
        access_queue.push_back(access_of(OP_READ,  0, 0, 0, 0, '0, 1'b1));
        // stored words at the ends of the selector space
        access_queue.push_back(access_of(OP_WRITE, 15, 7, 1, 0, '1, 1'b1));
        access_queue.push_back(access_of(OP_READ,  15, 7, 1, 0, '0, 1'b1));
        access_queue.push_back(access_of(OP_WRITE, 1, 0, 0, 0, '0, 1'b1));
        access_queue.push_back(access_of(OP_READ,  1, 0, 0, 0, '1, 1'b0));
        // thread-ID words in user mode, with one privileged write
        access_queue.push_back(access_of(OP_WRITE, 13, 0, 0, 2, 32'hA5A5_A5A5, 1'b0));
        access_queue.push_back(access_of(OP_READ,  13, 0, 0, 2, '0, 1'b0));
        access_queue.push_back(access_of(OP_WRITE, 13, 0, 0, 3, 32'h1234_5678, 1'b0));
        access_queue.push_back(access_of(OP_WRITE, 13, 0, 0, 3, 32'h5A5A_5A5A, 1'b1));
        access_queue.push_back(access_of(OP_READ,  13, 0, 0, 3, '0, 1'b0));
        // write-only operation words, prefetch flush and barriers
        access_queue.push_back(access_of(OP_WRITE, 7, 0, 5, 0, 32'hDEAD_BEEF, 1'b1));
        access_queue.push_back(access_of(OP_READ,  7, 0, 5, 0, '0, 1'b1));
        access_queue.push_back(access_of(OP_WRITE, 7, 0, 5, 0, '1, 1'b0));
        access_queue.push_back(access_of(OP_WRITE, 7, 0, 5, 4, '0, 1'b0));
        access_queue.push_back(access_of(OP_WRITE, 7, 0, 10, 5, '1, 1'b0));
        access_queue.push_back(access_of(OP_READ,  7, 0, 10, 4, '0, 1'b1));
        access_queue.push_back(access_of(OP_WRITE, 15, 5, 4, 4, '1, 1'b1));
        // process ID decodes only with first_op zero
        access_queue.push_back(access_of(OP_WRITE, 13, 1, 0, 1, '1, 1'b1));
        access_queue.push_back(access_of(OP_READ,  13, 0, 0, 1, '0, 1'b1));
        // unmapped corner
        access_queue.push_back(access_of(OP_READ,  15, 7, 15, 7, '1, 1'b1));
        access_queue.push_back(access_of(OP_WRITE, 15, 7, 15, 7, '1, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_phase(16, 48, 220);
        run_phase(48, 16, 210);
        run_phase(0, 0, 220);
        repeat (10) @(negedge i_clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/scr_pkg.sv
rtl/core/scr_ram.sv
rtl/core/scr_decode.sv
rtl/core/system_control_register_file_top.sv
rtl/core/scr_checker.sv
bench/system_control_register_file_top_test.sv
